/* src/pfc_pkg.sv */
// shared types, codes and helpers of the playfair cipher encryptor
package pfc_pkg;

  localparam int LETTERS = 26;
  localparam int CELLS   = 25;
  localparam int SIDE    = 5;

  localparam logic [7:0] ASCII_A = 8'd65;
  localparam logic [7:0] ASCII_Z = 8'd90;
  localparam logic [7:0] LOWER_A = 8'd97;
  localparam logic [7:0] LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_GAP = 8'd32;

  localparam logic [4:0] IDX_I = 5'd8;
  localparam logic [4:0] IDX_J = 5'd9;
  localparam logic [4:0] IDX_X = 5'd23;

  // letter marks after reset or at the start of a new square: only J taken
  localparam logic [LETTERS-1:0] USED_RESET = LETTERS'(1) << IDX_J;

  typedef enum logic [1:0] {
    FUNC_KEY      = 2'd0,
    FUNC_KEY_DONE = 2'd1,
    FUNC_TEXT     = 2'd2,
    FUNC_END      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PLACE,
    ST_CELL,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic fill_step;
    logic read_place;
    logic read_cell;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_fill;
    logic need_encode;
    logic fill_last;
    logic out_free;
    logic square_ready;
  } status_t;

  // row of a square cell number 0..24
  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // cell number from row and column: row * 5 + col
  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // column of a square cell number 0..24
  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [4:0] d;
    d = p - cell_at(row_of(p), 3'd0);
    return d[2:0];
  endfunction

  // step to the next row or column, wrapping at the edge
  function automatic logic [2:0] wrap_inc(input logic [2:0] x);
    return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
  endfunction

endpackage

/* src/pfc_item_if.sv */
// input channel: function code and raw character
interface pfc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_in;

  modport source (output valid, output func, output char_in, input ready);
  modport sink (input valid, input func, input char_in, output ready);
endinterface

/* src/pfc_digraph_if.sv */
// output channel: one encrypted digraph
interface pfc_digraph_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_first;
  logic [6:0] cipher_second;
  logic       is_last;

  modport source (output valid, output cipher_first, output cipher_second,
                  output is_last, input ready);
  modport sink (input valid, input cipher_first, input cipher_second,
                input is_last, output ready);
endinterface

/* src/playfair_cipher_encryptor.sv */
// playfair cipher encryptor top level: controller plus datapath
// A key, end or non-closing text item is handled in the idle state; a key-done item
//   on an unfinished square then walks the 26 letters through the square write port.
// An item that closes a digraph then passes through place read, cell read and output
//   load; the load waits for a free output register before the next item is taken.
// One item at a time: no new item is taken until the controller is back in idle.
// Reset (synchronous, active high) empties the square state; no clearing pass.
module playfair_cipher_encryptor import pfc_pkg::*; (
  input logic           clk,
  input logic           rst,
  pfc_item_if.sink      item,
  pfc_digraph_if.source digraph
);

  cmd_t    cmd;
  status_t status;

  pfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  pfc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (item.func),
    .char_in       (item.char_in),
    .out_valid     (digraph.valid),
    .out_ready     (digraph.ready),
    .cipher_first  (digraph.cipher_first),
    .cipher_second (digraph.cipher_second),
    .is_last       (digraph.is_last)
  );

`ifndef SYNTHESIS
  // at most one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.fill_step, cmd.read_place, cmd.read_cell, cmd.load_out}))
    else $error("controller issued overlapping commands");

  // a result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("output register overwritten");

  // the place read is always followed by the cell read
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    cmd.read_place |=> cmd.read_cell)
    else $error("cell read did not follow place read");

  // the last step of the key walk leaves the square ready
  a_fill_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.fill_step && status.fill_last) |=> status.square_ready)
    else $error("square not ready after key completion");
`endif

endmodule

/* src/pfc_datapath.sv */
// square storage, digraph assembly, table lookups and output register
module pfc_datapath import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [1:0] func,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] cipher_first,
  output logic [6:0] cipher_second,
  output logic       is_last
);

  // square memories
  logic [4:0] key_square [CELLS];
  logic [4:0] letter_place [LETTERS];

  // control state
  logic [LETTERS-1:0] used, used_next;
  logic [4:0]         fill, fill_next;
  logic               ready_sq, ready_sq_next;
  logic [4:0]         held, held_next;
  logic               held_valid, held_valid_next;
  logic [7:0]         prior, prior_next;
  logic [4:0]         fill_idx, fill_idx_next;

  // digraph under encryption
  logic [4:0] pair_a, pair_a_next;
  logic [4:0] pair_b, pair_b_next;
  logic       pair_last, pair_last_next;
  logic [4:0] place_a, place_b;
  logic [4:0] cell_a, cell_b;

  logic [7:0]         up_char;
  logic               is_letter;
  logic [4:0]         char_idx, text_idx;
  logic               doubled;
  logic [LETTERS-1:0] used_base;
  logic [4:0]         fill_base;
  logic               key_place, fill_place;
  logic               wr_en;
  logic [4:0]         wr_letter, wr_cell;
  logic               need_fill, need_encode;
  logic [2:0]         r1, c1, r2, c2;
  logic [4:0]         q1, q2;
  func_t              fn;

  // character decode
  always_comb begin
    fn = func_t'(func);
    up_char = (char_in >= LOWER_A && char_in <= LOWER_Z) ? char_in - CASE_GAP : char_in;
    is_letter = (up_char >= ASCII_A) && (up_char <= ASCII_Z);
    char_idx = 5'(up_char - ASCII_A);
    text_idx = (char_idx == IDX_J) ? IDX_I : char_idx;
    doubled = (up_char == prior);
  end

  // placement decisions and the single write port
  always_comb begin
    used_base = (fn == FUNC_KEY && ready_sq) ? USED_RESET : used;
    fill_base = (fn == FUNC_KEY && ready_sq) ? 5'd0 : fill;
    key_place = cmd.accept && fn == FUNC_KEY && is_letter && !used_base[char_idx]
                && fill_base < 5'(CELLS);
    fill_place = cmd.fill_step && !used[fill_idx] && fill < 5'(CELLS);
    wr_en = key_place || fill_place;
    wr_letter = cmd.fill_step ? fill_idx : char_idx;
    wr_cell = cmd.fill_step ? fill : fill_base;
  end

  // next state of the item-level registers
  always_comb begin
    used_next = used;
    fill_next = fill;
    ready_sq_next = ready_sq;
    held_next = held;
    held_valid_next = held_valid;
    prior_next = prior;
    fill_idx_next = fill_idx;
    pair_a_next = pair_a;
    pair_b_next = pair_b;
    pair_last_next = pair_last;
    need_fill = 1'b0;
    need_encode = 1'b0;
    case (fn)
      FUNC_KEY: begin
        if (ready_sq) begin
          ready_sq_next = 1'b0;
          held_next = 5'd0;
          held_valid_next = 1'b0;
          prior_next = 8'd0;
        end
        used_next = used_base;
        fill_next = fill_base;
        if (key_place) begin
          used_next[char_idx] = 1'b1;
          fill_next = fill_base + 5'd1;
        end
      end
      FUNC_KEY_DONE: begin
        if (!ready_sq) begin
          need_fill = 1'b1;
          fill_idx_next = 5'd0;
        end
      end
      FUNC_TEXT: begin
        if (ready_sq) begin
          prior_next = up_char;
          if (is_letter) begin
            pair_last_next = 1'b0;
            if (doubled) begin
              need_encode = 1'b1;
              if (held_valid) begin
                pair_a_next = held;
                pair_b_next = IDX_X;
                held_next = text_idx;
                held_valid_next = 1'b1;
              end else begin
                pair_a_next = IDX_X;
                pair_b_next = text_idx;
                held_next = 5'd0;
                held_valid_next = 1'b0;
              end
            end else if (held_valid) begin
              need_encode = 1'b1;
              pair_a_next = held;
              pair_b_next = text_idx;
              held_next = 5'd0;
              held_valid_next = 1'b0;
            end else begin
              held_next = text_idx;
              held_valid_next = 1'b1;
            end
          end
        end
      end
      FUNC_END: begin
        if (ready_sq) begin
          if (held_valid) begin
            need_encode = 1'b1;
            pair_a_next = held;
            pair_b_next = IDX_X;
            pair_last_next = 1'b1;
          end
          held_next = 5'd0;
          held_valid_next = 1'b0;
          prior_next = 8'd0;
        end
      end
      default: begin
        need_fill = 1'b0;
      end
    endcase
    // key completion walk over A..Z
    if (cmd.fill_step) begin
      if (fill_place) begin
        used_next[fill_idx] = 1'b1;
        fill_next = fill + 5'd1;
      end
      fill_idx_next = fill_idx + 5'd1;
      if (fill_idx == 5'(LETTERS - 1)) ready_sq_next = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= USED_RESET;
      fill <= 5'd0;
      ready_sq <= 1'b0;
      held <= 5'd0;
      held_valid <= 1'b0;
      prior <= 8'd0;
      fill_idx <= 5'd0;
    end else if (cmd.accept || cmd.fill_step) begin
      used <= used_next;
      fill <= fill_next;
      ready_sq <= ready_sq_next;
      held <= held_next;
      held_valid <= held_valid_next;
      prior <= prior_next;
      fill_idx <= fill_idx_next;
    end
  end

  // digraph letters captured with the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pair_a <= pair_a_next;
      pair_b <= pair_b_next;
      pair_last <= pair_last_next;
    end
  end

  // square memory writes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_square[wr_cell] <= wr_letter;
      letter_place[wr_letter] <= wr_cell;
    end
  end

  // cipher rules on the two places
  always_comb begin
    r1 = row_of(place_a);
    c1 = col_of(place_a);
    r2 = row_of(place_b);
    c2 = col_of(place_b);
    if (r1 == r2) begin
      q1 = cell_at(r1, wrap_inc(c1));
      q2 = cell_at(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      q1 = cell_at(wrap_inc(r1), c1);
      q2 = cell_at(wrap_inc(r2), c2);
    end else begin
      q1 = cell_at(r1, c2);
      q2 = cell_at(r2, c1);
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    if (cmd.read_place) begin
      place_a <= letter_place[pair_a];
      place_b <= letter_place[pair_b];
    end
    if (cmd.read_cell) begin
      cell_a <= key_square[q1];
      cell_b <= key_square[q2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cipher_first <= 7'(ASCII_A) + {2'b00, cell_a};
      cipher_second <= 7'(ASCII_A) + {2'b00, cell_b};
      is_last <= pair_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    status.need_fill = need_fill;
    status.need_encode = need_encode;
    status.fill_last = (fill_idx == 5'(LETTERS - 1));
    status.out_free = !out_valid || out_ready;
    status.square_ready = ready_sq;
  end

endmodule

/* src/pfc_ctrl.sv */
// controller state machine sequencing item intake, key fill and encryption
module pfc_ctrl import pfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (status.need_fill) state_next = ST_FILL;
          else if (status.need_encode) state_next = ST_PLACE;
        end
      end
      ST_FILL: begin
        if (status.fill_last) state_next = ST_IDLE;
      end
      ST_PLACE: state_next = ST_CELL;
      ST_CELL: state_next = ST_LOAD;
      ST_LOAD: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.accept = item_valid;
      end
      ST_FILL: cmd.fill_step = 1'b1;
      ST_PLACE: cmd.read_place = 1'b1;
      ST_CELL: cmd.read_cell = 1'b1;
      ST_LOAD: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
